>>> rtl/core/cafd_pkg.sv
// Package for the CAN acceptance filter dispatch core.
// Holds field layout of the filter slot registers, widths and the counter RAM request type.
// No dependencies.
package cafd_pkg;

  // Filter slot register layout
  localparam int unsigned ID_W     = 29;
  localparam int unsigned CFG_W    = 61;
  localparam int unsigned MASK_LSB = 29;
  localparam int unsigned LIST_BIT = 58;
  localparam int unsigned EN_BIT   = 59;
  localparam int unsigned EXT_BIT  = 60;

  // Bank geometry
  localparam int unsigned SLOT_COUNT          = 8;
  localparam int unsigned SLOT_AW             = 3;
  localparam int unsigned CFG_IDX_W           = 4;
  localparam int unsigned NUM_FILTERS_DEFAULT = 8;

  // Counters
  localparam int unsigned CNT_W = 32;

  // Single-port request into the hit counter RAM
  typedef struct packed {
    logic               rd_en;
    logic               wr_en;
    logic [SLOT_AW-1:0] addr;
    logic [CNT_W-1:0]   wdata;
  } ram_req_t;

endpackage

>>> rtl/core/can_acceptance_filter_dispatch_core.sv
// CAN acceptance filter dispatch core: frame sequencer, miss counter and result register.
// Depends on cafd_pkg, cafd_filter_bank and cafd_counter_ram.

// A received identifier is checked against NUM_FILTERS filter slots (mask or exact-list
// mode, matching only frames of the slot's own ID type). Each matching slot, lowest first,
// has its 32-bit hit counter bumped and yields one result; a frame that matches nothing
// bumps the miss counter and yields a single result. One frame is handled at a time: after
// the input transfer the sequencer goes through EVAL, then READ and UPD for each matching
// slot (MISS for a frame with no match); UPD and MISS load the output register and wait
// while the output stalls. The pace is set by the single-port hit counter RAM, which needs
// a read and a write-back for each matching slot. A new frame is taken as soon as
// the final result sits in the output register. Filter slots are written through the cfg
// channel, which is always ready; an index of 8 or more is ignored.
module can_acceptance_filter_dispatch_core #(
  parameter int unsigned NUM_FILTERS = cafd_pkg::NUM_FILTERS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cafd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cafd_pkg::CFG_W-1:0]     cfg_data,
  // frame input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [cafd_pkg::ID_W-1:0]      frame_id,
  input  logic                           extended,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           matched,
  output logic [cafd_pkg::SLOT_AW-1:0]   filter_index,
  output logic [cafd_pkg::CNT_W-1:0]     filter_hits,
  output logic [cafd_pkg::CNT_W-1:0]     misses_so_far,
  output logic                           last
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_MISS = 3'd4;

  logic [2:0]                     state;
  logic [2:0]                     state_next;
  logic [cafd_pkg::ID_W-1:0]      fid;
  logic                           ext;
  logic [NUM_FILTERS-1:0]         match_vec;
  logic [NUM_FILTERS-1:0]         pending;
  logic [cafd_pkg::SLOT_AW-1:0]   lowest;
  logic [cafd_pkg::SLOT_AW-1:0]   cur_idx;
  logic [cafd_pkg::CNT_W-1:0]     rdata;
  logic [cafd_pkg::CNT_W-1:0]     hits_next;
  logic [cafd_pkg::CNT_W-1:0]     miss_counter;
  logic                           out_free;
  logic                           in_xfer;
  cafd_pkg::ram_req_t             ram_req;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign hits_next = rdata + 32'd1;

  cafd_filter_bank #(
    .NUM_FILTERS (NUM_FILTERS)
  ) u_bank (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .frame_id  (fid),
    .extended  (ext),
    .match_vec (match_vec)
  );

  cafd_counter_ram u_ram (
    .clk   (clk),
    .rst   (rst),
    .req   (ram_req),
    .rdata (rdata)
  );

  // Lowest pending slot
  always_comb begin
    lowest = '0;
    for (int i = NUM_FILTERS - 1; i >= 0; i--) begin
      if (pending[i]) begin
        lowest = cafd_pkg::SLOT_AW'(i);
      end
    end
  end

  // Counter RAM access: read in READ, write back in UPD, so one entry never overlaps
  always_comb begin
    ram_req.rd_en = (state == ST_READ);
    ram_req.wr_en = (state == ST_UPD) && out_free;
    ram_req.addr  = (state == ST_READ) ? lowest : cur_idx;
    ram_req.wdata = hits_next;
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_next = (match_vec == '0) ? ST_MISS : ST_READ;
      end
      ST_READ: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          state_next = (pending == '0) ? ST_IDLE : ST_READ;
        end
      end
      ST_MISS: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pending      <= '0;
      miss_counter <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_EVAL) begin
        pending <= match_vec;
      end else if (state == ST_READ) begin
        pending <= pending & (pending - 1'b1);
      end
      if ((state == ST_MISS) && out_free) begin
        miss_counter <= miss_counter + 32'd1;
      end
      if (((state == ST_UPD) || (state == ST_MISS)) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Frame, slot and result payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      fid <= frame_id;
      ext <= extended;
    end
    if (state == ST_READ) begin
      cur_idx <= lowest;
    end
    if ((state == ST_UPD) && out_free) begin
      matched       <= 1'b1;
      filter_index  <= cur_idx;
      filter_hits   <= hits_next;
      misses_so_far <= miss_counter;
      last          <= (pending == '0);
    end else if ((state == ST_MISS) && out_free) begin
      matched       <= 1'b0;
      filter_index  <= '0;
      filter_hits   <= '0;
      misses_so_far <= miss_counter + 32'd1;
      last          <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  // Write-back only follows the read of the same frame step
  a_upd_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) |-> ($past(state) == ST_UPD || $past(state) == ST_READ))
    else $error("update state entered without a counter read");

  // Every counter write-back produces a match result
  a_wr_gives_result: assert property (@(posedge clk) disable iff (rst)
    ram_req.wr_en |=> (out_valid && matched && filter_hits == $past(ram_req.wdata)))
    else $error("counter write-back without matching result");

  // Miss counter moves only together with a miss result
  a_miss_only_on_miss: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(miss_counter)) |-> (out_valid && !matched && last))
    else $error("miss counter changed without a miss result");

  // No slot left over when a new frame may be taken
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (pending == '0))
    else $error("pending slots left while idle");
`endif

endmodule

>>> rtl/core/cafd_filter_bank.sv
// Filter slot registers and the per-slot acceptance comparators.
// Depends on cafd_pkg.
module cafd_filter_bank #(
  parameter int unsigned NUM_FILTERS = cafd_pkg::NUM_FILTERS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [cafd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cafd_pkg::CFG_W-1:0]     cfg_data,
  // frame under test
  input  logic [cafd_pkg::ID_W-1:0]      frame_id,
  input  logic                           extended,
  output logic [NUM_FILTERS-1:0]         match_vec
);

  logic [cafd_pkg::CFG_W-1:0] slot [cafd_pkg::SLOT_COUNT];

  // One slot against the frame; only frames of the slot's own ID type can match
  function automatic logic slot_hit(input logic [cafd_pkg::CFG_W-1:0] cfg,
                                    input logic [cafd_pkg::ID_W-1:0]  fid,
                                    input logic                       ext);
    logic [cafd_pkg::ID_W-1:0] fid_id;
    logic [cafd_pkg::ID_W-1:0] fmask;
    logic                      hit;
    fid_id = cfg[cafd_pkg::ID_W-1:0];
    fmask  = cfg[cafd_pkg::MASK_LSB +: cafd_pkg::ID_W];
    if (!cfg[cafd_pkg::EN_BIT] || (cfg[cafd_pkg::EXT_BIT] != ext)) begin
      hit = 1'b0;
    end else if (cfg[cafd_pkg::LIST_BIT]) begin
      hit = (fid == fid_id);
    end else begin
      hit = ((fid & fmask) == (fid_id & fmask));
    end
    return hit;
  endfunction

  // Slot registers; out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cafd_pkg::SLOT_COUNT; i++) begin
        slot[i] <= '0;
      end
    end else if (cfg_we && (cfg_index < cafd_pkg::CFG_IDX_W'(cafd_pkg::SLOT_COUNT))) begin
      slot[cfg_index[cafd_pkg::SLOT_AW-1:0]] <= cfg_data;
    end
  end

  // Comparators for the slots in use, all in parallel
  always_comb begin
    for (int i = 0; i < NUM_FILTERS; i++) begin
      match_vec[i] = slot_hit(slot[i], frame_id, extended);
    end
  end

endmodule

>>> rtl/core/cafd_counter_ram.sv
// Hit counter store: single-port 8 x 32 RAM with registered read data.
// Per-entry valid bits make unwritten entries read as zero after reset. Depends on cafd_pkg.
module cafd_counter_ram (
  input  logic                       clk,
  input  logic                       rst,
  input  cafd_pkg::ram_req_t         req,
  output logic [cafd_pkg::CNT_W-1:0] rdata
);

  logic [cafd_pkg::CNT_W-1:0]      mem [cafd_pkg::SLOT_COUNT];
  logic [cafd_pkg::SLOT_COUNT-1:0] valid;

  // Array write and registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata <= valid[req.addr] ? mem[req.addr] : '0;
    end
  end

  // Entry valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.addr] <= 1'b1;
    end
  end

endmodule

>>> dv/cafd_dispatch_checker.sv
`timescale 1ns / 100ps
// Checker for the CAN acceptance filter dispatch core: watches the cfg, frame and result
// channels, keeps its own filter bank and counters, and compares every result transfer.
// Depends on cafd_pkg.
module cafd_dispatch_checker #(
  parameter int unsigned NUM_FILTERS = cafd_pkg::NUM_FILTERS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [cafd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cafd_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [cafd_pkg::ID_W-1:0]      frame_id,
  input  logic                           extended,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           matched,
  input  logic [cafd_pkg::SLOT_AW-1:0]   filter_index,
  input  logic [cafd_pkg::CNT_W-1:0]     filter_hits,
  input  logic [cafd_pkg::CNT_W-1:0]     misses_so_far,
  input  logic                           last,
  output int                             fail_count,
  output int                             pending,
  output int                             hit_results,
  output int                             miss_results
);

  localparam int unsigned ID_W  = cafd_pkg::ID_W;
  localparam int unsigned CFG_W = cafd_pkg::CFG_W;
  localparam int unsigned CNT_W = cafd_pkg::CNT_W;
  localparam int unsigned AW    = cafd_pkg::SLOT_AW;
  localparam int unsigned SLOTS = cafd_pkg::SLOT_COUNT;
  localparam int unsigned SHOWN = 10;

  typedef struct packed {
    logic             matched;
    logic [AW-1:0]    slot;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic             last;
  } dispatch_res_t;

  dispatch_res_t    awaited_results[$];
  logic [CFG_W-1:0] slot_cfg  [SLOTS];
  logic [CNT_W-1:0] slot_hits [SLOTS];
  logic [CNT_W-1:0] miss_total;

  // Does one filter slot accept this identifier?
  function automatic bit slot_accepts(input logic [CFG_W-1:0] cfg,
                                      input logic [ID_W-1:0] fid, input logic ext);
    logic [ID_W-1:0] want;
    logic [ID_W-1:0] care;
    want = cfg[ID_W-1:0];
    care = cfg[cafd_pkg::MASK_LSB +: ID_W];
    if (!cfg[cafd_pkg::EN_BIT] || (cfg[cafd_pkg::EXT_BIT] != ext)) return 1'b0;
    if (cfg[cafd_pkg::LIST_BIT]) return fid == want;
    return (fid & care) == (want & care);
  endfunction

  // Bump counters for one frame and queue the results it should produce
  function automatic void dispatch_frame(input logic [ID_W-1:0] fid, input logic ext);
    dispatch_res_t r;
    int            first;
    first = awaited_results.size();
    for (int s = 0; s < NUM_FILTERS && s < SLOTS; s++) begin
      if (slot_accepts(slot_cfg[s], fid, ext)) begin
        slot_hits[s] = slot_hits[s] + 1'b1;
        r.matched = 1'b1;
        r.slot    = AW'(s);
        r.hits    = slot_hits[s];
        r.misses  = miss_total;
        r.last    = 1'b0;
        awaited_results.push_back(r);
      end
    end
    if (awaited_results.size() == first) begin
      miss_total = miss_total + 1'b1;
      r.matched = 1'b0;
      r.slot    = '0;
      r.hits    = '0;
      r.misses  = miss_total;
      r.last    = 1'b1;
      awaited_results.push_back(r);
    end else begin
      awaited_results[awaited_results.size()-1].last = 1'b1;
    end
  endfunction

  // Sample all three channels at the rising edge
  always @(posedge clk) begin
    dispatch_res_t got;
    dispatch_res_t want;
    if (rst) begin
      foreach (slot_cfg[s]) begin
        slot_cfg[s]  = '0;
        slot_hits[s] = '0;
      end
      miss_total = '0;
      awaited_results.delete();
      fail_count   = 0;
      hit_results  = 0;
      miss_results = 0;
    end else begin
      // register write; indexes past the bank are dropped
      if (cfg_valid && cfg_ready && (cfg_index < SLOTS))
        slot_cfg[cfg_index[AW-1:0]] = cfg_data;

      if (in_valid && in_ready)
        dispatch_frame(frame_id, extended);

      if (out_valid && out_ready) begin
        got = {matched, filter_index, filter_hits, misses_so_far, last};
        if (got.matched === 1'b1) hit_results++;
        else miss_results++;
        if (awaited_results.size() == 0) begin
          if (fail_count < SHOWN)
            $display("[%0t] result with nothing awaited: %s=%0b slot=%0d hits=%0d",
                     $realtime, "matched", got.matched, got.slot, got.hits,
                     " misses=%0d last=%0b", got.misses, got.last);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if ((got.matched !== want.matched) || (got.slot !== want.slot) ||
              (got.hits !== want.hits) || (got.misses !== want.misses) ||
              (got.last !== want.last)) begin
            if (fail_count < SHOWN) begin
              $display("[%0t] result mismatch", $realtime);
              $display("  expected matched=%0b slot=%0d hits=%0d misses=%0d last=%0b",
                       want.matched, want.slot, want.hits, want.misses, want.last);
              $display("  actual   matched=%0b slot=%0d hits=%0d misses=%0d last=%0b",
                       got.matched, got.slot, got.hits, got.misses, got.last);
            end
            fail_count++;
          end
        end
      end
    end
    pending = awaited_results.size();
  end

endmodule

>>> dv/tb_can_acceptance_filter_dispatch_core.sv
`timescale 1ns / 100ps
// Testbench top for the CAN acceptance filter dispatch core: clock, reset, filter bank
// programming, frame stimulus and result back-pressure; verdict from cafd_dispatch_checker.
// Depends on cafd_pkg, the core and the checker.
module tb_can_acceptance_filter_dispatch_core;

  localparam int unsigned ID_W        = cafd_pkg::ID_W;
  localparam int unsigned CFG_W       = cafd_pkg::CFG_W;
  localparam int unsigned IDX_W       = cafd_pkg::CFG_IDX_W;
  localparam int unsigned SLOTS       = cafd_pkg::SLOT_COUNT;
  localparam int unsigned MASK_LSB    = cafd_pkg::MASK_LSB;
  localparam int unsigned NUM_FILTERS = cafd_pkg::NUM_FILTERS_DEFAULT;
  localparam int unsigned TOP_IDX     = (1 << IDX_W) - 1;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 48;
  localparam int unsigned RUN_LIMIT   = 5_000_000;

  typedef enum int {BANK_OPEN, BANK_SHUT, BANK_FULL, BANK_MIXED} bank_kind_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [IDX_W-1:0]     cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [ID_W-1:0]      frame_id;
  logic                 extended;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 matched;
  logic [cafd_pkg::SLOT_AW-1:0] filter_index;
  logic [cafd_pkg::CNT_W-1:0]   filter_hits;
  logic [cafd_pkg::CNT_W-1:0]   misses_so_far;
  logic                 last;

  int fail_count;
  int pending;
  int hit_results;
  int miss_results;

  logic             quiet_tail = 1'b0;
  logic [CFG_W-1:0] bank [SLOTS];
  int               frames_sent = 0;
  int               banks_loaded = 0;
  int unsigned      stall_left = 0;

  can_acceptance_filter_dispatch_core #(.NUM_FILTERS(NUM_FILTERS)) dut (
    .clk, .rst,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .frame_id, .extended,
    .out_valid, .out_ready, .matched, .filter_index, .filter_hits, .misses_so_far, .last
  );

  cafd_dispatch_checker #(.NUM_FILTERS(NUM_FILTERS)) u_check (
    .clk, .rst,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .frame_id, .extended,
    .out_valid, .out_ready, .matched, .filter_index, .filter_hits, .misses_so_far, .last,
    .fail_count, .pending, .hit_results, .miss_results
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result back-pressure: random stall bursts, none in the tail
  always @(negedge clk) begin
    if (quiet_tail) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 20) begin
      stall_left = $urandom_range(0, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Run limit
  initial begin
    #(RUN_LIMIT);
    $display("Run limit reached with %0d results still awaited", pending);
    $display("FAILURE");
    $finish;
  end

  function automatic logic [CFG_W-1:0] slot_word(input logic ext, input logic en,
                                                 input logic list, input logic [ID_W-1:0] care,
                                                 input logic [ID_W-1:0] id);
    return {ext, en, list, care, id};
  endfunction

  // One register write transfer; cfg_valid stays up for a following write
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Program all slots, then a write to an index past the bank
  task automatic load_bank();
    for (int s = 0; s < SLOTS; s++) write_reg(IDX_W'(s), bank[s]);
    write_reg(IDX_W'($urandom_range(SLOTS, TOP_IDX)), CFG_W'({$urandom(), $urandom()}));
    @(negedge clk);
    cfg_valid <= 1'b0;
    banks_loaded++;
  endtask

  // One frame transfer, with an optional idle burst ahead of it
  task automatic send_frame(input logic [ID_W-1:0] fid, input logic ext);
    if (!quiet_tail && ($urandom_range(0, 99) < 25)) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    frame_id <= fid;
    extended <= ext;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    frames_sent++;
  endtask

  // Drop valid and wait for every awaited result, plus a short settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    logic [CFG_W-1:0] v;
    logic [CFG_W-1:0] c;
    logic [ID_W-1:0]  care;
    logic [ID_W-1:0]  noise;
    logic [ID_W-1:0]  fid;
    logic             ext;
    logic             open_ext;
    bank_kind_t       kind;

    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    frame_id  = '0;
    extended  = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed bank: mask and list slots of both ID types, a disabled slot
    bank[0] = slot_word(1'b0, 1'b1, 1'b0, 29'h0000_07FF, 29'h0000_0123);
    bank[1] = slot_word(1'b1, 1'b1, 1'b1, 29'h0,         29'h1ABC_DEF0);
    bank[2] = slot_word(1'b0, 1'b1, 1'b0, 29'h0,         29'h0000_0555);
    bank[3] = slot_word(1'b1, 1'b0, 1'b1, 29'h0,         29'h1ABC_DEF0);
    bank[4] = slot_word(1'b0, 1'b1, 1'b1, 29'h0,         29'h0000_07FF);
    bank[5] = slot_word(1'b1, 1'b1, 1'b0, 29'h1FFF_FFFF, 29'h0);
    bank[6] = slot_word(1'b1, 1'b1, 1'b1, 29'h0,         29'h1FFF_FFFF);
    bank[7] = slot_word(1'b1, 1'b1, 1'b0, 29'h1FFF_0000, 29'h1ABC_0000);
    load_bank();

    // Directed frames, incl. standard frames with high id bits set
    send_frame(29'h0000_0123, 1'b0);
    send_frame(29'h1FFF_F123, 1'b0);
    send_frame(29'h0000_07FF, 1'b0);
    send_frame(29'h1FFF_FFFF, 1'b0);
    send_frame(29'h0000_0000, 1'b0);
    send_frame(29'h1ABC_DEF0, 1'b1);
    send_frame(29'h1ABC_DEF1, 1'b1);
    send_frame(29'h0000_0000, 1'b1);
    send_frame(29'h1FFF_FFFF, 1'b1);
    send_frame(29'h0001_2345, 1'b1);
    send_frame(29'h1ABC_DEF0, 1'b0);
    send_frame(29'h0FFF_FFFF, 1'b1);
    drain();

    // Random phases: open, shut and all-ones banks first, then mixed banks
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       kind = BANK_OPEN;
        1:       kind = BANK_SHUT;
        2:       kind = BANK_FULL;
        default: kind = BANK_MIXED;
      endcase
      open_ext = $urandom_range(0, 1);
      for (int s = 0; s < SLOTS; s++) begin
        v = CFG_W'({$urandom(), $urandom()});
        case (kind)
          BANK_OPEN: v = slot_word(open_ext, 1'b1, 1'b0, '0, v[ID_W-1:0]);
          BANK_SHUT: v = '0;
          BANK_FULL: v = '1;
          default: begin
            case ($urandom_range(0, 3))
              0:       care = '0;
              1:       care = '1;
              2:       care = ID_W'($urandom());
              default: care = ID_W'($urandom() & $urandom() & $urandom());
            endcase
            v[MASK_LSB +: ID_W]     = care;
            v[cafd_pkg::EN_BIT]   = ($urandom_range(0, 99) < 85);
            v[cafd_pkg::LIST_BIT] = ($urandom_range(0, 99) < 35);
            // standard filters mostly hold 11-bit ids
            if (!v[cafd_pkg::EXT_BIT] && $urandom_range(0, 1)) v[ID_W-1:11] = '0;
            // overlapping slots so one frame hits several
            if (s > 0 && ($urandom_range(0, 99) < 35)) begin
              v[ID_W-1:0]          = bank[s-1][ID_W-1:0];
              v[cafd_pkg::EXT_BIT] = bank[s-1][cafd_pkg::EXT_BIT];
            end
          end
        endcase
        bank[s] = v;
      end
      load_bank();
      if (p == PHASES - 1) quiet_tail = 1'b1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        noise = ID_W'($urandom());
        c     = bank[cafd_pkg::SLOT_AW'($urandom_range(0, SLOTS - 1))];
        if ($urandom_range(0, 99) < 70) begin
          // aimed at one slot: exact id, or random bits outside its mask
          ext = c[cafd_pkg::EXT_BIT];
          if (c[cafd_pkg::LIST_BIT]) begin
            fid = c[ID_W-1:0];
            if ($urandom_range(0, 9) == 0) fid[$urandom_range(0, ID_W - 1)] ^= 1'b1;
          end else begin
            care = c[MASK_LSB +: ID_W];
            fid  = (c[ID_W-1:0] & care) | (noise & ~care);
          end
        end else begin
          fid = noise;
          ext = $urandom_range(0, 1);
          if (!ext && $urandom_range(0, 1)) fid[ID_W-1:11] = '0;
        end
        send_frame(fid, ext);
      end
      drain();
    end

    $display("Covered %0d frames over %0d filter bank settings (open, shut, all-ones, mixed)",
             frames_sent, banks_loaded);
    $display("Checked %0d filter hit results and %0d miss results", hit_results, miss_results);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d result failures", fail_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
